### hw/rtl/gb9c_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gb9c_pkg
// shared constants, item codes and dot merge functions for the character
// generator
// ----------------------------------------------------------------------------
package gb9c_pkg;

	localparam int TEXT_LINES_DEF  = 25;
	localparam int TEXT_COLS_DEF   = 80;
	localparam int GLYPH_ROWS_DEF  = 14;
	localparam int FONT_CHARS_DEF  = 256;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int CELL_W = 9;

	localparam int KIND_W = 2;
	localparam int CODE_W = 8;
	localparam int ROW_W  = 4;
	localparam int DOTS_W = 8;
	localparam int LINE_W = 5;
	localparam int COL_W  = 7;
	localparam int BIDX_W = 7;
	localparam int BYTE_W = 8;

	typedef enum logic [KIND_W-1:0] {
		OP_LOAD = 2'd0,
		OP_DRAW = 2'd1,
		OP_READ = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	// width of the job word carried from front to back
	function automatic int job_bits(input int font_aw, input int bank_aw);
		return KIND_W + 1 + font_aw + 2 * bank_aw + 1 + 3 + DOTS_W;
	endfunction

	function automatic logic [BYTE_W-1:0] first_keep(input logic [2:0] phase);
		logic [BYTE_W-1:0] k;
		unique case (phase)
			3'd0: k = 8'h00;
			3'd1: k = 8'hC0;
			3'd2: k = 8'hE0;
			3'd3: k = 8'hF0;
			3'd4: k = 8'hF8;
			3'd5: k = 8'hFC;
			3'd6: k = 8'hFE;
			3'd7: k = 8'hFF;
		endcase
		return k;
	endfunction

	function automatic logic [BYTE_W-1:0] second_keep(input logic [2:0] phase);
		logic [BYTE_W-1:0] k;
		unique case (phase)
			3'd0: k = 8'h3F;
			3'd1: k = 8'h1F;
			3'd2: k = 8'h0F;
			3'd3: k = 8'h07;
			3'd4: k = 8'h03;
			3'd5: k = 8'h01;
			3'd6: k = 8'h00;
			3'd7: k = 8'h00;
		endcase
		return k;
	endfunction

	function automatic logic [BYTE_W-1:0] merge_first(input logic [BYTE_W-1:0] old,
			input logic [DOTS_W-1:0] dots, input logic [2:0] phase);
		logic [3:0] sh;
		sh = 4'(phase) + 4'd1;
		return (old & first_keep(phase)) | (dots >> sh);
	endfunction

	function automatic logic [BYTE_W-1:0] merge_second(input logic [BYTE_W-1:0] old,
			input logic [DOTS_W-1:0] dots, input logic [2:0] phase);
		logic [2:0] sh;
		sh = 3'd7 - phase;
		return (old & second_keep(phase)) | 8'(dots << sh);
	endfunction

endpackage

### hw/rtl/gb9c_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gb9c_ram
// single port ram with registered read data
// ----------------------------------------------------------------------------
module gb9c_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

### hw/rtl/gb9c_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gb9c_front
// accepts items, checks positions and works out font and frame bank addresses
// ----------------------------------------------------------------------------
module gb9c_front #(
	parameter int TEXT_LINES = gb9c_pkg::TEXT_LINES_DEF,
	parameter int TEXT_COLS  = gb9c_pkg::TEXT_COLS_DEF,
	parameter int GLYPH_ROWS = gb9c_pkg::GLYPH_ROWS_DEF,
	parameter int FONT_CHARS = gb9c_pkg::FONT_CHARS_DEF,
	localparam int RowBytes  = (TEXT_COLS * gb9c_pkg::CELL_W + 7) / 8,
	localparam int HalfRow   = (RowBytes + 1) / 2,
	localparam int BankDepth = TEXT_LINES * GLYPH_ROWS * HalfRow,
	localparam int BankAw    = $clog2(BankDepth),
	localparam int FontAw    = $clog2(FONT_CHARS * GLYPH_ROWS),
	localparam int JobW      = gb9c_pkg::job_bits(FontAw, BankAw)
) (
	input  logic                        cmd_valid,
	output logic                        cmd_ready,
	input  logic [gb9c_pkg::KIND_W-1:0] kind,
	input  logic [gb9c_pkg::CODE_W-1:0] char_code,
	input  logic [gb9c_pkg::ROW_W-1:0]  glyph_row,
	input  logic [gb9c_pkg::DOTS_W-1:0] glyph_bits,
	input  logic [gb9c_pkg::LINE_W-1:0] text_line,
	input  logic [gb9c_pkg::COL_W-1:0]  text_col,
	input  logic [gb9c_pkg::BIDX_W-1:0] byte_index,
	input  logic                        clear_busy,
	output logic                        push_valid,
	input  logic                        push_ready,
	output logic [JobW-1:0]             push_data
);

	localparam int LineStride = GLYPH_ROWS * HalfRow;

	typedef struct packed {
		gb9c_pkg::op_t               op;
		logic                        ok;
		logic [FontAw-1:0]           font_addr;
		logic [BankAw-1:0]           addr0;
		logic [BankAw-1:0]           addr1;
		logic                        sel;
		logic [2:0]                  phase;
		logic [gb9c_pkg::DOTS_W-1:0] dots;
	} job_t;

	job_t          job;
	gb9c_pkg::op_t op;
	logic [10:0]   col_x9;
	logic [7:0]    first_byte;
	logic [6:0]    off1;
	logic [7:0]    off0;
	logic          code_ok;
	logic          row_ok;
	logic          line_ok;
	logic          col_ok;
	logic          bidx_ok;
	int            line_base;
	int            read_addr;

	assign cmd_ready  = push_ready && !clear_busy;
	assign push_valid = cmd_valid && !clear_busy;
	assign push_data  = job;

	assign op         = gb9c_pkg::op_t'(kind);
	assign col_x9     = 11'({text_col, 3'b000}) + 11'(text_col);
	assign first_byte = col_x9[10:3];
	assign off1       = first_byte[7:1];
	assign off0       = 8'(off1) + 8'(first_byte[0]);

	assign code_ok = int'(char_code) < FONT_CHARS;
	assign row_ok  = int'(glyph_row) < GLYPH_ROWS;
	assign line_ok = int'(text_line) < TEXT_LINES;
	assign col_ok  = int'(text_col) < TEXT_COLS;
	assign bidx_ok = int'(byte_index) < RowBytes;

	assign line_base = int'(text_line) * LineStride;
	assign read_addr = line_base + int'(glyph_row) * HalfRow + int'(byte_index[6:1]);

	always_comb begin
		job       = '0;
		job.op    = op;
		job.phase = text_col[2:0];
		job.dots  = glyph_bits;
		unique case (op)
			gb9c_pkg::OP_LOAD: begin
				job.ok        = code_ok && row_ok;
				job.font_addr = FontAw'(int'(char_code) * GLYPH_ROWS + int'(glyph_row));
			end
			gb9c_pkg::OP_DRAW: begin
				job.ok        = code_ok && line_ok && col_ok;
				job.font_addr = FontAw'(int'(char_code) * GLYPH_ROWS);
				job.addr0     = BankAw'(line_base + int'(off0));
				job.addr1     = BankAw'(line_base + int'(off1));
				job.sel       = first_byte[0];
			end
			gb9c_pkg::OP_READ: begin
				job.ok    = line_ok && row_ok && bidx_ok;
				job.addr0 = BankAw'(read_addr);
				job.addr1 = BankAw'(read_addr);
				job.sel   = byte_index[0];
			end
			gb9c_pkg::OP_NONE: begin
				job.ok = 1'b0;
			end
		endcase
	end

endmodule

### hw/rtl/gb9c_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gb9c_queue
// short first-in first-out queue between front and back
// ----------------------------------------------------------------------------
module gb9c_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = gb9c_pkg::QUEUE_DEPTH_DEF,
	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CntW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PtrW-1:0]  wr_q;
	logic [PtrW-1:0]  rd_q;
	logic [CntW-1:0]  cnt_q;
	logic             push_fire;
	logic             pop_fire;

	assign push_ready = cnt_q != CntW'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = mem_q[rd_q];
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push_fire) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_fire) begin
				wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
			end
			if (pop_fire) begin
				rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
			end
			if (push_fire && !pop_fire) begin
				cnt_q <= cnt_q + CntW'(1);
			end else if (pop_fire && !push_fire) begin
				cnt_q <= cnt_q - CntW'(1);
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(DEPTH))
		else $error("queue count above depth");

	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push_fire && !pop_fire) |=> (cnt_q == $past(cnt_q) + CntW'(1)))
		else $error("queue count lost a transfer");

endmodule

### hw/rtl/gb9c_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gb9c_back
// executes jobs on the font store and the two frame byte banks, clears the
// frame after reset and holds the result register
// ----------------------------------------------------------------------------
module gb9c_back #(
	parameter int TEXT_LINES = gb9c_pkg::TEXT_LINES_DEF,
	parameter int TEXT_COLS  = gb9c_pkg::TEXT_COLS_DEF,
	parameter int GLYPH_ROWS = gb9c_pkg::GLYPH_ROWS_DEF,
	parameter int FONT_CHARS = gb9c_pkg::FONT_CHARS_DEF,
	localparam int RowBytes  = (TEXT_COLS * gb9c_pkg::CELL_W + 7) / 8,
	localparam int HalfRow   = (RowBytes + 1) / 2,
	localparam int BankDepth = TEXT_LINES * GLYPH_ROWS * HalfRow,
	localparam int BankAw    = $clog2(BankDepth),
	localparam int FontDepth = FONT_CHARS * GLYPH_ROWS,
	localparam int FontAw    = $clog2(FontDepth),
	localparam int JobW      = gb9c_pkg::job_bits(FontAw, BankAw)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        pop_valid,
	output logic                        pop_ready,
	input  logic [JobW-1:0]             pop_data,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic [gb9c_pkg::BYTE_W-1:0] read_byte,
	output logic                        in_range,
	output logic                        clear_busy
);

	localparam int RowW = $clog2(GLYPH_ROWS);

	typedef struct packed {
		gb9c_pkg::op_t               op;
		logic                        ok;
		logic [FontAw-1:0]           font_addr;
		logic [BankAw-1:0]           addr0;
		logic [BankAw-1:0]           addr1;
		logic                        sel;
		logic [2:0]                  phase;
		logic [gb9c_pkg::DOTS_W-1:0] dots;
	} job_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DRAW_RD,
		ST_DRAW_WR,
		ST_READ_WAIT
	} state_t;

	state_t                      state_q;
	job_t                        head;
	logic                        take;
	logic                        out_free;
	logic [BankAw-1:0]           clr_q;
	logic [BankAw-1:0]           a0_q;
	logic [BankAw-1:0]           a1_q;
	logic [FontAw-1:0]           fa_q;
	logic [RowW-1:0]             row_q;
	logic                        sel_q;
	logic [2:0]                  phase_q;
	logic                        res_valid_q;
	logic [gb9c_pkg::BYTE_W-1:0] res_byte_q;
	logic                        res_ok_q;

	logic                        b_we;
	logic [BankAw-1:0]           b_addr0;
	logic [BankAw-1:0]           b_addr1;
	logic [gb9c_pkg::BYTE_W-1:0] wd0;
	logic [gb9c_pkg::BYTE_W-1:0] wd1;
	logic [gb9c_pkg::BYTE_W-1:0] rd0;
	logic [gb9c_pkg::BYTE_W-1:0] rd1;
	logic                        f_we;
	logic [FontAw-1:0]           f_addr;
	logic [gb9c_pkg::DOTS_W-1:0] f_rd;
	logic [gb9c_pkg::BYTE_W-1:0] first_old;
	logic [gb9c_pkg::BYTE_W-1:0] second_old;
	logic [gb9c_pkg::BYTE_W-1:0] first_new;
	logic [gb9c_pkg::BYTE_W-1:0] second_new;
	logic                        last_row;

	assign head       = job_t'(pop_data);
	assign out_free   = !res_valid_q || res_ready;
	assign pop_ready  = (state_q == ST_IDLE) && out_free;
	assign take       = pop_ready && pop_valid;
	assign clear_busy = state_q == ST_CLEAR;
	assign res_valid  = res_valid_q;
	assign read_byte  = res_byte_q;
	assign in_range   = res_ok_q;
	assign last_row   = row_q == RowW'(GLYPH_ROWS - 1);

	// first byte of the cell sits in bank 1 when its byte index is odd
	assign first_old  = sel_q ? rd1 : rd0;
	assign second_old = sel_q ? rd0 : rd1;
	assign first_new  = gb9c_pkg::merge_first(first_old, f_rd, phase_q);
	assign second_new = gb9c_pkg::merge_second(second_old, f_rd, phase_q);

	always_comb begin
		b_we    = 1'b0;
		b_addr0 = a0_q;
		b_addr1 = a1_q;
		wd0     = '0;
		wd1     = '0;
		f_we    = 1'b0;
		f_addr  = fa_q;
		unique case (state_q)
			ST_CLEAR: begin
				b_we    = 1'b1;
				b_addr0 = clr_q;
				b_addr1 = clr_q;
			end
			ST_IDLE: begin
				// row 0 of a draw and a read-back are issued straight from the queue head
				b_addr0 = head.addr0;
				b_addr1 = head.addr1;
				f_addr  = head.font_addr;
				f_we    = take && head.ok && (head.op == gb9c_pkg::OP_LOAD);
			end
			ST_DRAW_WR: begin
				b_we = 1'b1;
				wd0  = sel_q ? second_new : first_new;
				wd1  = sel_q ? first_new : second_new;
			end
			ST_DRAW_RD, ST_READ_WAIT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			a0_q        <= '0;
			a1_q        <= '0;
			fa_q        <= '0;
			row_q       <= '0;
			sel_q       <= 1'b0;
			phase_q     <= '0;
			res_valid_q <= 1'b0;
			res_byte_q  <= '0;
			res_ok_q    <= 1'b0;
		end else begin
			if (res_valid_q && res_ready && !take) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (clr_q == BankAw'(BankDepth - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + BankAw'(1);
					end
				end
				ST_IDLE: begin
					if (take) begin
						sel_q   <= head.sel;
						phase_q <= head.phase;
						if (head.ok && head.op == gb9c_pkg::OP_DRAW) begin
							state_q     <= ST_DRAW_WR;
							res_valid_q <= 1'b0;
							a0_q        <= head.addr0;
							a1_q        <= head.addr1;
							fa_q        <= head.font_addr;
							row_q       <= '0;
						end else if (head.ok && head.op == gb9c_pkg::OP_READ) begin
							state_q     <= ST_READ_WAIT;
							res_valid_q <= 1'b0;
						end else begin
							res_valid_q <= 1'b1;
							res_byte_q  <= '0;
							res_ok_q    <= head.ok;
						end
					end
				end
				ST_DRAW_RD: begin
					state_q <= ST_DRAW_WR;
				end
				ST_DRAW_WR: begin
					if (last_row) begin
						state_q     <= ST_IDLE;
						res_valid_q <= 1'b1;
						res_byte_q  <= '0;
						res_ok_q    <= 1'b1;
					end else begin
						state_q <= ST_DRAW_RD;
						a0_q    <= a0_q + BankAw'(HalfRow);
						a1_q    <= a1_q + BankAw'(HalfRow);
						fa_q    <= fa_q + FontAw'(1);
						row_q   <= row_q + RowW'(1);
					end
				end
				ST_READ_WAIT: begin
					state_q     <= ST_IDLE;
					res_valid_q <= 1'b1;
					res_byte_q  <= sel_q ? rd1 : rd0;
					res_ok_q    <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	gb9c_ram #(
		.WIDTH(gb9c_pkg::DOTS_W),
		.DEPTH(FontDepth)
	) u_font (
		.clk  (clk),
		.we   (f_we),
		.addr (f_addr),
		.wdata(head.dots),
		.rdata(f_rd)
	);

	gb9c_ram #(
		.WIDTH(gb9c_pkg::BYTE_W),
		.DEPTH(BankDepth)
	) u_bank0 (
		.clk  (clk),
		.we   (b_we),
		.addr (b_addr0),
		.wdata(wd0),
		.rdata(rd0)
	);

	gb9c_ram #(
		.WIDTH(gb9c_pkg::BYTE_W),
		.DEPTH(BankDepth)
	) u_bank1 (
		.clk  (clk),
		.we   (b_we),
		.addr (b_addr1),
		.wdata(wd1),
		.rdata(rd1)
	);

	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAW_RD || state_q == ST_DRAW_WR || state_q == ST_READ_WAIT)
		|-> !res_valid_q)
		else $error("result register busy while a job runs");

	a_draw_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAW_WR && last_row) |=> (state_q == ST_IDLE && res_valid_q && res_ok_q))
		else $error("draw finished without a result");

	a_read_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ_WAIT) |=> (state_q == ST_IDLE && res_valid_q && res_ok_q))
		else $error("read-back finished without a result");

endmodule

### hw/rtl/glyph_blit_9dot_cells.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_blit_9dot_cells
// character generator drawing 9-pixel text cells into a packed frame store
// ----------------------------------------------------------------------------
// latency from transfer to result runs through the queue and the back-end states:
// a load or a rejected item is answered from ST_IDLE, a read-back via ST_READ_WAIT,
// a draw via ST_DRAW_WR for row 0, then ST_DRAW_RD and ST_DRAW_WR per further row;
// no new item is taken until the last one is done and the result slot is free
// after reset the frame banks are cleared to zero, one word a cycle, over all
// TEXT_LINES * GLYPH_ROWS * ceil(row bytes / 2) words of each bank (15750), cmd_ready low
module glyph_blit_9dot_cells #(
	parameter int TEXT_LINES  = gb9c_pkg::TEXT_LINES_DEF,
	parameter int TEXT_COLS   = gb9c_pkg::TEXT_COLS_DEF,
	parameter int GLYPH_ROWS  = gb9c_pkg::GLYPH_ROWS_DEF,
	parameter int FONT_CHARS  = gb9c_pkg::FONT_CHARS_DEF,
	parameter int QUEUE_DEPTH = gb9c_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	output logic                        cmd_ready,
	input  logic [gb9c_pkg::KIND_W-1:0] kind,
	input  logic [gb9c_pkg::CODE_W-1:0] char_code,
	input  logic [gb9c_pkg::ROW_W-1:0]  glyph_row,
	input  logic [gb9c_pkg::DOTS_W-1:0] glyph_bits,
	input  logic [gb9c_pkg::LINE_W-1:0] text_line,
	input  logic [gb9c_pkg::COL_W-1:0]  text_col,
	input  logic [gb9c_pkg::BIDX_W-1:0] byte_index,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic [gb9c_pkg::BYTE_W-1:0] read_byte,
	output logic                        in_range
);

	localparam int RowBytes  = (TEXT_COLS * gb9c_pkg::CELL_W + 7) / 8;
	localparam int HalfRow   = (RowBytes + 1) / 2;
	localparam int BankDepth = TEXT_LINES * GLYPH_ROWS * HalfRow;
	localparam int BankAw    = $clog2(BankDepth);
	localparam int FontAw    = $clog2(FONT_CHARS * GLYPH_ROWS);
	localparam int JobW      = gb9c_pkg::job_bits(FontAw, BankAw);

	logic            push_valid;
	logic            push_ready;
	logic [JobW-1:0] push_data;
	logic            pop_valid;
	logic            pop_ready;
	logic [JobW-1:0] pop_data;
	logic            clear_busy;

	gb9c_front #(
		.TEXT_LINES(TEXT_LINES),
		.TEXT_COLS (TEXT_COLS),
		.GLYPH_ROWS(GLYPH_ROWS),
		.FONT_CHARS(FONT_CHARS)
	) u_front (
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.kind      (kind),
		.char_code (char_code),
		.glyph_row (glyph_row),
		.glyph_bits(glyph_bits),
		.text_line (text_line),
		.text_col  (text_col),
		.byte_index(byte_index),
		.clear_busy(clear_busy),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	gb9c_queue #(
		.WIDTH(JobW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	gb9c_back #(
		.TEXT_LINES(TEXT_LINES),
		.TEXT_COLS (TEXT_COLS),
		.GLYPH_ROWS(GLYPH_ROWS),
		.FONT_CHARS(FONT_CHARS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.read_byte (read_byte),
		.in_range  (in_range),
		.clear_busy(clear_busy)
	);

endmodule

### tb/gb9c_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gb9c_frame_checker
// watches the command and result channels of the character generator, keeps
// its own font and frame copies, predicts the answer to every command
// transfer and compares each result transfer against the oldest prediction
// ----------------------------------------------------------------------------
module gb9c_frame_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	input  logic                        cmd_ready,
	input  logic [gb9c_pkg::KIND_W-1:0] kind,
	input  logic [gb9c_pkg::CODE_W-1:0] char_code,
	input  logic [gb9c_pkg::ROW_W-1:0]  glyph_row,
	input  logic [gb9c_pkg::DOTS_W-1:0] glyph_bits,
	input  logic [gb9c_pkg::LINE_W-1:0] text_line,
	input  logic [gb9c_pkg::COL_W-1:0]  text_col,
	input  logic [gb9c_pkg::BIDX_W-1:0] byte_index,
	input  logic                        res_valid,
	input  logic                        res_ready,
	input  logic [gb9c_pkg::BYTE_W-1:0] read_byte,
	input  logic                        in_range,
	output int                          fails,
	output int                          outstanding
);
	import gb9c_pkg::*;

	localparam int ROWS        = GLYPH_ROWS_DEF;
	localparam int LINES       = TEXT_LINES_DEF;
	localparam int COLS        = TEXT_COLS_DEF;
	localparam int CHARS       = FONT_CHARS_DEF;
	localparam int ROW_BYTES   = (COLS * CELL_W + 7) / 8;
	localparam int FRAME_BYTES = LINES * ROWS * ROW_BYTES;

	typedef struct packed {
		logic [BYTE_W-1:0] pixels;
		logic              hit;
	} answer_t;

	logic [DOTS_W-1:0] glyph_mem [CHARS*ROWS];
	logic [BYTE_W-1:0] pixel_mem [FRAME_BYTES];
	answer_t           answers_due [$];
	int                mismatch_count;
	int                result_no;

	function automatic int pixel_addr(input int line, input int row, input int b);
		return (line * ROWS + row) * ROW_BYTES + b;
	endfunction

	function automatic void blit_cell(input int code, input int line, input int col);
		int                lead;
		int                phase;
		int                a;
		logic [DOTS_W-1:0] dots;
		logic [BYTE_W-1:0] keep;
		logic [BYTE_W-1:0] part;
		lead  = (col * CELL_W) / 8;
		phase = col % 8;
		for (int r = 0; r < ROWS; r++) begin
			dots = glyph_mem[code*ROWS+r];
			// phase 7 keeps the blank bit sitting in the lead byte
			if (phase < 7) begin
				keep = (phase == 0) ? 8'h00 : ~(8'hFF >> (phase + 1));
				part = dots >> (phase + 1);
				a = pixel_addr(line, r, lead);
				pixel_mem[a] = (pixel_mem[a] & keep) | part;
			end
			if (lead + 1 < ROW_BYTES) begin
				keep = 8'hFF >> (phase + 2);
				part = dots << (7 - phase);
				a = pixel_addr(line, r, lead + 1);
				pixel_mem[a] = (pixel_mem[a] & keep) | part;
			end
		end
	endfunction

	function automatic answer_t predict_answer(input op_t op, input int code, input int row,
			input logic [DOTS_W-1:0] dots, input int line, input int col, input int b);
		answer_t ans;
		ans = '0;
		case (op)
			OP_LOAD: begin
				if (code < CHARS && row < ROWS) begin
					glyph_mem[code*ROWS+row] = dots;
					ans.hit = 1'b1;
				end
			end
			OP_DRAW: begin
				if (code < CHARS && line < LINES && col < COLS) begin
					blit_cell(code, line, col);
					ans.hit = 1'b1;
				end
			end
			OP_READ: begin
				if (line < LINES && row < ROWS && b < ROW_BYTES) begin
					ans.pixels = pixel_mem[pixel_addr(line, row, b)];
					ans.hit = 1'b1;
				end
			end
			default: begin
			end
		endcase
		return ans;
	endfunction

	task automatic report(input string what, input int got, input int want);
		$display("%0t ns: result %0d %s: got %0h, want %0h", $time, result_no, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			for (int i = 0; i < FRAME_BYTES; i++) pixel_mem[i] = '0;
			answers_due.delete();
			mismatch_count = 0;
			result_no = 0;
			fails <= 0;
			outstanding <= 0;
		end else begin
			if (res_valid && res_ready) begin
				if (answers_due.size() == 0) begin
					report("transfer with nothing outstanding", int'(read_byte), 0);
				end else begin
					want = answers_due.pop_front();
					if (read_byte !== want.pixels) begin
						report("read_byte", int'(read_byte), int'(want.pixels));
					end
					if (in_range !== want.hit) begin
						report("in_range", int'(in_range), int'(want.hit));
					end
				end
				result_no++;
			end
			if (cmd_valid && cmd_ready) begin
				answers_due.push_back(predict_answer(op_t'(kind), int'(char_code),
						int'(glyph_row), glyph_bits, int'(text_line), int'(text_col),
						int'(byte_index)));
			end
			fails <= mismatch_count;
			outstanding <= answers_due.size();
		end
	end

endmodule

### tb/glyph_blit_9dot_cells_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_blit_9dot_cells_tb
// drives font loads, cell draws, frame read-backs and OP_NONE items into the character
// generator with random gaps and result stalls, one long result hold-off
// included; a checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module glyph_blit_9dot_cells_tb;
	import gb9c_pkg::*;

	localparam int ROWS        = GLYPH_ROWS_DEF;
	localparam int LINES       = TEXT_LINES_DEF;
	localparam int COLS        = TEXT_COLS_DEF;
	localparam int CHARS       = FONT_CHARS_DEF;
	localparam int ROW_BYTES   = (COLS * CELL_W + 7) / 8;
	localparam int ITEM_TARGET = 730;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN       = 2 * ROWS + 12;

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               cmd_valid  = 1'b0;
	logic               cmd_ready;
	logic [KIND_W-1:0]  kind       = '0;
	logic [CODE_W-1:0]  char_code  = '0;
	logic [ROW_W-1:0]   glyph_row  = '0;
	logic [DOTS_W-1:0]  glyph_bits = '0;
	logic [LINE_W-1:0]  text_line  = '0;
	logic [COL_W-1:0]   text_col   = '0;
	logic [BIDX_W-1:0]  byte_index = '0;
	logic               res_valid;
	logic               res_ready  = 1'b0;
	logic [BYTE_W-1:0]  read_byte;
	logic               in_range;
	int                 fails;
	int                 outstanding;

	logic               hold_go    = 1'b0;
	int                 burst_left;
	int                 calm_left;
	int                 sent;
	logic [ROWS-1:0]    rows_loaded [CHARS];
	logic [CODE_W-1:0]  full_codes [$];

	glyph_blit_9dot_cells u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.kind       (kind),
		.char_code  (char_code),
		.glyph_row  (glyph_row),
		.glyph_bits (glyph_bits),
		.text_line  (text_line),
		.text_col   (text_col),
		.byte_index (byte_index),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.read_byte  (read_byte),
		.in_range   (in_range)
	);

	gb9c_frame_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.kind        (kind),
		.char_code   (char_code),
		.glyph_row   (glyph_row),
		.glyph_bits  (glyph_bits),
		.text_line   (text_line),
		.text_col    (text_col),
		.byte_index  (byte_index),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.read_byte   (read_byte),
		.in_range    (in_range),
		.fails       (fails),
		.outstanding (outstanding)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("glyph_blit_9dot_cells_tb: errors");
		$finish;
	end

	function automatic int next_gap();
		int pick;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		pick = $urandom_range(0, 99);
		if (pick < 4) begin
			calm_left = $urandom_range(10, 40);
			return 0;
		end
		if (pick < 45) return 0;
		if (pick < 85) return $urandom_range(1, 3);
		if (pick < 96) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_item(input op_t op, input logic [CODE_W-1:0] code,
			input logic [ROW_W-1:0] row, input logic [DOTS_W-1:0] dots,
			input logic [LINE_W-1:0] line, input logic [COL_W-1:0] col,
			input logic [BIDX_W-1:0] b);
		int   gap;
		logic was_full;
		gap = next_gap();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid  <= 1'b1;
		kind       <= op;
		char_code  <= code;
		glyph_row  <= row;
		glyph_bits <= dots;
		text_line  <= line;
		text_col   <= col;
		byte_index <= b;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		sent++;
		if (op == OP_LOAD && row < ROWS) begin
			was_full = &rows_loaded[code];
			rows_loaded[code][row] = 1'b1;
			if (!was_full && &rows_loaded[code]) full_codes.push_back(code);
		end
	endtask

	task automatic load_glyph(input logic [CODE_W-1:0] code);
		int                order [ROWS];
		int                j;
		int                t;
		logic [DOTS_W-1:0] dots;
		for (int i = 0; i < ROWS; i++) order[i] = i;
		for (int i = ROWS - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		for (int i = 0; i < ROWS; i++) begin
			case ($urandom_range(0, 9))
				0: dots = 8'hFF;
				1: dots = 8'h00;
				default: dots = DOTS_W'($urandom);
			endcase
			send_item(OP_LOAD, code, ROW_W'(order[i]), dots, LINE_W'($urandom),
					COL_W'($urandom), BIDX_W'($urandom));
		end
	endtask

	// result side: short and long stalls, calm stretches, one long hold-off
	initial begin
		int stall_left;
		int calm_rx;
		int pick;
		bit hold_done;
		stall_left = 0;
		calm_rx = 0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_go && !hold_done) begin
				hold_done = 1'b1;
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (stall_left > 0) begin
				res_ready <= 1'b0;
				stall_left--;
			end else begin
				res_ready <= 1'b1;
				if (calm_rx > 0) begin
					calm_rx--;
				end else begin
					pick = $urandom_range(0, 99);
					if (pick < 3) calm_rx = $urandom_range(50, 200);
					else if (pick < 8) stall_left = $urandom_range(15, 50);
					else if (pick < 35) stall_left = $urandom_range(1, 3);
				end
			end
		end
	end

	initial begin
		int                pick;
		int                n;
		int                lead;
		int                b;
		logic [CODE_W-1:0] code;
		logic [LINE_W-1:0] line;
		logic [COL_W-1:0]  col;
		burst_left = 0;
		calm_left = 0;
		sent = 0;
		for (int i = 0; i < CHARS; i++) rows_loaded[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, every kind, rejected positions, phase 0 and 7
		load_glyph(8'd255);
		send_item(OP_LOAD, 8'd255, 4'd0, 8'hFF, 5'd0, 7'd0, 7'd0);
		send_item(OP_LOAD, 8'd0, 4'd15, 8'h00, 5'd31, 7'd127, 7'd127);
		send_item(OP_DRAW, 8'd255, 4'd0, 8'h00, 5'd0, 7'd0, 7'd0);
		send_item(OP_DRAW, 8'd255, 4'd15, 8'hFF, 5'd0, 7'd7, 7'd127);
		send_item(OP_DRAW, 8'd255, 4'd0, 8'h00, 5'd24, 7'd79, 7'd0);
		send_item(OP_DRAW, 8'd255, 4'd0, 8'h00, 5'd25, 7'd0, 7'd0);
		send_item(OP_DRAW, 8'd255, 4'd0, 8'h00, 5'd0, 7'd80, 7'd0);
		send_item(OP_READ, 8'd0, 4'd0, 8'h00, 5'd0, 7'd0, 7'd0);
		send_item(OP_READ, 8'd255, 4'd0, 8'hFF, 5'd0, 7'd127, 7'd8);
		send_item(OP_READ, 8'd0, 4'd13, 8'h00, 5'd24, 7'd0, 7'd89);
		send_item(OP_READ, 8'd0, 4'd15, 8'h00, 5'd31, 7'd0, 7'd127);
		send_item(OP_NONE, 8'd255, 4'd15, 8'hFF, 5'd31, 7'd127, 7'd127);

		// random: glyph loads followed by draws and nearby read-backs, plus noise
		hold_go <= 1'b1;
		burst_left = 40;
		while (sent < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 14 || full_codes.size() == 0) begin
				case ($urandom_range(0, 9))
					0: code = 8'd0;
					1: code = 8'd255;
					default: code = CODE_W'($urandom);
				endcase
				load_glyph(code);
			end else if (pick < 55) begin
				code = full_codes[$urandom_range(0, full_codes.size() - 1)];
				case ($urandom_range(0, 9))
					0: line = 5'd0;
					1: line = LINE_W'(LINES - 1);
					default: line = LINE_W'($urandom_range(0, LINES - 1));
				endcase
				case ($urandom_range(0, 9))
					0: col = 7'd0;
					1: col = COL_W'(COLS - 1);
					default: col = COL_W'($urandom_range(0, COLS - 1));
				endcase
				send_item(OP_DRAW, code, ROW_W'($urandom), DOTS_W'($urandom), line, col,
						BIDX_W'($urandom));
				lead = (int'(col) * CELL_W) / 8;
				n = $urandom_range(1, 3);
				for (int i = 0; i < n; i++) begin
					b = lead + int'($urandom_range(0, 3)) - 1;
					if (b < 0) b = 0;
					if (b > ROW_BYTES - 1) b = ROW_BYTES - 1;
					send_item(OP_READ, CODE_W'($urandom), ROW_W'($urandom_range(0, ROWS - 1)),
							DOTS_W'($urandom), line, COL_W'($urandom), BIDX_W'(b));
				end
			end else if (pick < 72) begin
				if ($urandom_range(0, 99) < 85) begin
					send_item(OP_READ, CODE_W'($urandom), ROW_W'($urandom_range(0, ROWS - 1)),
							DOTS_W'($urandom), LINE_W'($urandom_range(0, LINES - 1)),
							COL_W'($urandom), BIDX_W'($urandom_range(0, ROW_BYTES - 1)));
				end else begin
					send_item(OP_READ, CODE_W'($urandom), ROW_W'($urandom), DOTS_W'($urandom),
							LINE_W'($urandom), COL_W'($urandom), BIDX_W'($urandom));
				end
			end else if (pick < 86) begin
				send_item(OP_LOAD, CODE_W'($urandom), ROW_W'($urandom_range(0, 15)),
						DOTS_W'($urandom), LINE_W'($urandom), COL_W'($urandom),
						BIDX_W'($urandom));
			end else if (pick < 92) begin
				send_item(OP_NONE, CODE_W'($urandom), ROW_W'($urandom), DOTS_W'($urandom),
						LINE_W'($urandom), COL_W'($urandom), BIDX_W'($urandom));
			end else begin
				code = full_codes[$urandom_range(0, full_codes.size() - 1)];
				if ($urandom_range(0, 1)) begin
					line = LINE_W'($urandom_range(LINES, 31));
					col = COL_W'($urandom);
				end else begin
					line = LINE_W'($urandom);
					col = COL_W'($urandom_range(COLS, 127));
				end
				send_item(OP_DRAW, code, ROW_W'($urandom), DOTS_W'($urandom), line, col,
						BIDX_W'($urandom));
			end
		end

		cmd_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (fails == 0 && outstanding == 0) begin
			$display("glyph_blit_9dot_cells_tb: clean");
		end else begin
			$display("glyph_blit_9dot_cells_tb: errors");
		end
		$finish;
	end

endmodule
